// File: design/fts_pkg.sv
`timescale 1ns / 1ps
// fts_pkg: shared types and constants for the binary indexed tree sum engine.
// Used by fts_front, fts_queue, fts_back and fenwick_tree_sum_engine. No dependencies.

package fts_pkg;

    localparam int POS_W   = 17;  // index and size width
    localparam int DELTA_W = 32;
    localparam int SUM_W   = 64;

    localparam logic [POS_W-1:0] SIZE_RESET = 17'h10000;

    localparam logic [1:0] CMD_POINT_ADD = 2'd0;
    localparam logic [1:0] CMD_RANGE_ADD = 2'd1;
    localparam logic [1:0] CMD_RANGE_SUM = 2'd2;

    // What the back end has to do with one word
    typedef enum logic [1:0] {
        OP_REJECT,
        OP_UPDATE,
        OP_QUERY
    } op_t;

    // Classified word handed from front to back.
    // Update: add delta along pos_a, then add -delta along pos_b if b_en.
    // Query:  prefix(pos_a) minus prefix(pos_b) if b_en.
    typedef struct packed {
        op_t                       op;
        logic [POS_W-1:0]          pos_a;
        logic [POS_W-1:0]          pos_b;
        logic                      b_en;
        logic [POS_W-1:0]          limit;
        logic signed [DELTA_W-1:0] delta;
    } desc_t;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_WALK_A,
        BK_WALK_B,
        BK_RESULT
    } back_state_t;

endpackage

// File: design/fts_front.sv
`timescale 1ns / 1ps
// fts_front: accepts input words, checks indices and turns them into walk descriptors.
// Depends on fts_pkg.

module fts_front #(
    parameter int MAX_POSITIONS = 65536
) (
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        cmd,
    input  logic [fts_pkg::POS_W-1:0]         first_index,
    input  logic [fts_pkg::POS_W-1:0]         last_index,
    input  logic signed [fts_pkg::DELTA_W-1:0] delta,
    input  logic [fts_pkg::POS_W-1:0]         size_in_use,
    input  logic                              clearing,
    input  logic                              push_ready,
    output logic                              push_valid,
    output fts_pkg::desc_t                    push_desc
);

    localparam logic [fts_pkg::POS_W-1:0] MAX_LIMIT = fts_pkg::POS_W'(MAX_POSITIONS);
    localparam logic [fts_pkg::POS_W-1:0] ONE = fts_pkg::POS_W'(1);

    logic [fts_pkg::POS_W-1:0] limit;
    logic                      over;
    logic                      lo_ok;
    logic                      range_ok;

    // clamp size to 1..MAX_POSITIONS
    assign over  = ({15'd0, size_in_use} > 32'(MAX_POSITIONS));
    assign limit = (size_in_use == '0) ? ONE : (over ? MAX_LIMIT : size_in_use);

    assign lo_ok    = (first_index != '0) && (first_index <= limit);
    assign range_ok = (first_index != '0) && (first_index <= last_index)
                      && (last_index <= limit);

    assign in_ready   = push_ready && !clearing;
    assign push_valid = in_valid && !clearing;

    always_comb
    begin
        push_desc       = '0;
        push_desc.limit = limit;
        push_desc.delta = delta;
        push_desc.op    = fts_pkg::OP_REJECT;
        case (cmd)
            fts_pkg::CMD_POINT_ADD:
            begin
                push_desc.pos_a = first_index;
                push_desc.b_en  = 1'b0;
                if (lo_ok)
                begin
                    push_desc.op = fts_pkg::OP_UPDATE;
                end
            end
            fts_pkg::CMD_RANGE_ADD:
            begin
                push_desc.pos_a = first_index;
                push_desc.pos_b = last_index + ONE;
                push_desc.b_en  = (last_index < limit);
                if (range_ok)
                begin
                    push_desc.op = fts_pkg::OP_UPDATE;
                end
            end
            fts_pkg::CMD_RANGE_SUM:
            begin
                push_desc.pos_a = last_index;
                push_desc.pos_b = first_index - ONE;
                push_desc.b_en  = (first_index != ONE);
                if (range_ok)
                begin
                    push_desc.op = fts_pkg::OP_QUERY;
                end
            end
            default:
            begin
                push_desc.op = fts_pkg::OP_REJECT;
            end
        endcase
    end

endmodule

// File: design/fts_queue.sv
`timescale 1ns / 1ps
// fts_queue: two-entry descriptor FIFO between front and back.
// Depends on fts_pkg.

module fts_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  fts_pkg::desc_t push_desc,
    output logic           pop_valid,
    input  logic           pop_ready,
    output fts_pkg::desc_t pop_desc
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    fts_pkg::desc_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// File: design/fts_back.sv
`timescale 1ns / 1ps
// fts_back: tree walker over the partial-sum memory, clearing pass and result register.
// Depends on fts_pkg.

module fts_back #(
    parameter int MAX_POSITIONS = 65536
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              pop_valid,
    output logic                              pop_ready,
    input  fts_pkg::desc_t                    pop_desc,
    output logic                              clearing,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [fts_pkg::SUM_W-1:0]  range_sum,
    output logic                              status
);

    localparam int AW = $clog2(MAX_POSITIONS);
    localparam int PW = fts_pkg::POS_W;
    localparam int SW = fts_pkg::SUM_W;
    localparam int DW = fts_pkg::DELTA_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

    logic [SW-1:0] mem [MAX_POSITIONS];
    logic [SW-1:0] rdata_reg;

    fts_pkg::back_state_t state_reg, state_next;
    fts_pkg::desc_t       desc_reg, desc_next;
    logic [PW-1:0]        pos_reg, pos_next;
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;
    logic [SW-1:0]        acc_reg, acc_next;
    logic [AW-1:0]        clr_addr_reg, clr_addr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SW-1:0]        sum_reg, sum_next;
    logic                 status_reg, status_next;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [SW-1:0]        mem_wdata;
    logic                 mem_re;
    logic [AW-1:0]        mem_raddr;

    logic                 is_add;
    logic                 second;
    logic [SW-1:0]        amount;
    logic [SW-1:0]        amount_cur;
    logic [PW-1:0]        low_bit;
    logic [PW:0]          pos_up;
    logic [PW-1:0]        pos_step;
    logic                 walk_done;
    logic                 slot_free;

    assign is_add     = (desc_reg.op == fts_pkg::OP_UPDATE);
    assign second     = (state_reg == fts_pkg::BK_WALK_B);
    assign amount     = {{(SW-DW){desc_reg.delta[DW-1]}}, desc_reg.delta};
    assign amount_cur = second ? (SW'(0) - amount) : amount;

    // update walk climbs by the lowest set bit, prefix walk clears it
    assign low_bit  = pos_reg & (~pos_reg + PW'(1));
    assign pos_up   = {1'b0, pos_reg} + {1'b0, low_bit};
    assign pos_step = is_add ? ((pos_up > {1'b0, desc_reg.limit}) ? '0 : pos_up[PW-1:0])
                             : (pos_reg & (pos_reg - PW'(1)));

    assign walk_done = (pos_reg == '0) && !pend_reg;
    assign slot_free = !out_valid_reg || out_ready;

    assign mem_raddr = AW'(pos_reg - PW'(1));
    assign clearing  = (state_reg == fts_pkg::BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign range_sum = sum_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        desc_next      = desc_reg;
        pos_next       = pos_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        clr_addr_next  = clr_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sum_next       = sum_reg;
        status_next    = status_reg;
        pop_ready      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = pend_addr_reg;
        mem_wdata      = rdata_reg + amount_cur;
        mem_re         = 1'b0;

        case (state_reg)
            fts_pkg::BK_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + AW'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = fts_pkg::BK_IDLE;
                end
            end
            fts_pkg::BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    desc_next = pop_desc;
                    pos_next  = pop_desc.pos_a;
                    acc_next  = '0;
                    if (pop_desc.op == fts_pkg::OP_REJECT)
                    begin
                        state_next = fts_pkg::BK_RESULT;
                    end
                    else
                    begin
                        state_next = fts_pkg::BK_WALK_A;
                    end
                end
            end
            fts_pkg::BK_WALK_A,
            fts_pkg::BK_WALK_B:
            begin
                // one read issued per cycle, data lands next cycle
                if (pos_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = mem_raddr;
                    pos_next       = pos_step;
                end
                if (pend_reg)
                begin
                    if (is_add)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        acc_next = second ? (acc_reg - rdata_reg) : (acc_reg + rdata_reg);
                    end
                end
                // last write must land before the other walk reads
                if (walk_done)
                begin
                    if (!second && desc_reg.b_en)
                    begin
                        pos_next   = desc_reg.pos_b;
                        state_next = fts_pkg::BK_WALK_B;
                    end
                    else
                    begin
                        state_next = fts_pkg::BK_RESULT;
                    end
                end
            end
            fts_pkg::BK_RESULT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = (desc_reg.op == fts_pkg::OP_QUERY) ? acc_reg : '0;
                    status_next    = (desc_reg.op == fts_pkg::OP_REJECT);
                    state_next     = fts_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = fts_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fts_pkg::BK_CLEAR;
            pend_reg      <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg      <= desc_next;
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
        sum_reg       <= sum_next;
        status_reg    <= status_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

// File: design/fenwick_tree_sum_engine.sv
`timescale 1ns / 1ps
// fenwick_tree_sum_engine: top level of the binary indexed tree sum engine.
// Depends on fts_pkg, fts_front, fts_queue, fts_back.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | input     | in_valid / in_ready      | cmd, first_index, last_index, delta
//  out      | output    | out_valid / out_ready    | range_sum, status
//  cfg      | input     | cfg_wr_en (no wait)      | cfg_wr_data -> size_in_use
//
// Steps per word in the back: a reject is popped, then its result is written. An
// update or a query is popped, walks the k entries on its first tree walk and the m
// entries on its second, then writes its result; an unneeded second walk is skipped.
// The single read port of the partial-sum memory sets the pace: one entry per cycle,
// then a last read-modify-write and a turn-around for each walk.
// After reset a clearing pass zeroes the memory, with in_ready low.
// The two-entry queue lets the front take words while the back walks or the output stalls.

module fenwick_tree_sum_engine #(
    parameter int MAX_POSITIONS = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fts_pkg::POS_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [fts_pkg::POS_W-1:0]           first_index,
    input  logic [fts_pkg::POS_W-1:0]           last_index,
    input  logic signed [fts_pkg::DELTA_W-1:0]  delta,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [fts_pkg::SUM_W-1:0]    range_sum,
    output logic                                status
);

    logic [fts_pkg::POS_W-1:0] size_reg;
    logic                      clearing;
    logic                      push_valid;
    logic                      push_ready;
    fts_pkg::desc_t            push_desc;
    logic                      pop_valid;
    logic                      pop_ready;
    fts_pkg::desc_t            pop_desc;

    // size register, to be written by the user only while idle; the block itself does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= fts_pkg::SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    // front: range checks and command decode
    fts_front #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .first_index (first_index),
        .last_index  (last_index),
        .delta       (delta),
        .size_in_use (size_reg),
        .clearing    (clearing),
        .push_ready  (push_ready),
        .push_valid  (push_valid),
        .push_desc   (push_desc)
    );

    fts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_desc   (pop_desc)
    );

    // back: memory walks and result register
    fts_back #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_desc  (pop_desc),
        .clearing  (clearing),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .range_sum (range_sum),
        .status    (status)
    );

    // rejected words never carry a sum
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> range_sum == '0)
        else $error("rejected word with nonzero sum");

    // no result can appear while the memory is still being cleared
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid && !pop_ready)
        else $error("back active during clearing pass");

    // the back takes one word and is busy on the next cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready |=> !pop_ready)
        else $error("back took two words in a row");

endmodule

// File: bench/fenwick_tree_sum_engine_checker.sv
`timescale 1ns / 1ps
// fenwick_tree_sum_engine_checker: watches the word channels and the size register of
// the tree sum engine, predicts every answer and compares. Depends on fts_pkg.

module fenwick_tree_sum_engine_checker #(
    parameter int MAX_POSITIONS = 65536
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [fts_pkg::POS_W-1:0]           cfg_wr_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [1:0]                          cmd,
    input  logic [fts_pkg::POS_W-1:0]           first_index,
    input  logic [fts_pkg::POS_W-1:0]           last_index,
    input  logic signed [fts_pkg::DELTA_W-1:0]  delta,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [fts_pkg::SUM_W-1:0]    range_sum,
    input  logic                                status,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count
);

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;
    localparam int   MAX_REPORTS     = 10;

    typedef struct {
        logic signed [fts_pkg::SUM_W-1:0] sum;
        logic                             status;
    } answer_t;

    // Tree nodes start zeroed; reset is applied once, at time zero.
    bit [fts_pkg::SUM_W-1:0]   node_sums [1:MAX_POSITIONS];
    logic [fts_pkg::POS_W-1:0] size_setting = fts_pkg::SIZE_RESET;
    answer_t                   expected_answers [$];
    int                        failures = 0;
    int                        compared = 0;

    function automatic int unsigned usable_size(logic [fts_pkg::POS_W-1:0] setting);
        if (setting == 0)
            return 1;
        if (setting > MAX_POSITIONS)
            return MAX_POSITIONS;
        return 32'(setting);
    endfunction

    function automatic void walk_add(int unsigned pos, logic [fts_pkg::SUM_W-1:0] amount,
                                     int unsigned limit);
        while (pos >= 1 && pos <= limit)
        begin
            node_sums[pos] += amount;
            pos += pos & (~pos + 1);
        end
    endfunction

    function automatic logic [fts_pkg::SUM_W-1:0] prefix_total(int unsigned pos);
        logic [fts_pkg::SUM_W-1:0] acc;
        acc = '0;
        while (pos != 0)
        begin
            if (pos <= MAX_POSITIONS)
                acc += node_sums[pos];
            pos &= pos - 1;
        end
        return acc;
    endfunction

    // Applies one word to the tree copy and returns the answer it must produce.
    function automatic answer_t predict_answer(logic [1:0] op, int unsigned lo, int unsigned hi,
                                               logic [fts_pkg::DELTA_W-1:0] d);
        answer_t                   ans;
        int unsigned               n;
        logic [fts_pkg::SUM_W-1:0] amount;
        n          = usable_size(size_setting);
        amount     = {{(fts_pkg::SUM_W - fts_pkg::DELTA_W){d[fts_pkg::DELTA_W-1]}}, d};
        ans.sum    = '0;
        ans.status = STATUS_DONE;
        case (op)
            fts_pkg::CMD_POINT_ADD:
            begin
                if (lo >= 1 && lo <= n)
                    walk_add(lo, amount, n);
                else
                    ans.status = STATUS_REJECTED;
            end
            fts_pkg::CMD_RANGE_ADD, fts_pkg::CMD_RANGE_SUM:
            begin
                if (lo >= 1 && lo <= hi && hi <= n)
                begin
                    if (op == fts_pkg::CMD_RANGE_ADD)
                    begin
                        walk_add(lo, amount, n);
                        // the cancelling update is dropped when it lands past the end
                        if (hi + 1 <= n)
                            walk_add(hi + 1, -amount, n);
                    end
                    else
                        ans.sum = prefix_total(hi) - prefix_total(lo - 1);
                end
                else
                    ans.status = STATUS_REJECTED;
            end
            default:
                ans.status = STATUS_REJECTED;
        endcase
        return ans;
    endfunction

    function automatic void note_failure(string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, what);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        answer_t want;
        if (!rst_n)
        begin
            size_setting = fts_pkg::SIZE_RESET;
            expected_answers.delete();
        end
        else
        begin
            // answers first: a word taken at this edge cannot be answered at it
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                    note_failure($sformatf("answer with none expected: sum %0d status %0b",
                                           range_sum, status));
                else
                begin
                    want = expected_answers.pop_front();
                    compared++;
                    if (range_sum !== want.sum || status !== want.status)
                        note_failure($sformatf(
                            "answer %0d: expected sum %0d status %0b, got sum %0d status %0b",
                            compared, want.sum, want.status, range_sum, status));
                end
            end
            if (in_valid && in_ready)
                expected_answers.push_back(predict_answer(cmd, 32'(first_index),
                                                          32'(last_index), delta));
            if (cfg_wr_en)
                size_setting = cfg_wr_data;
        end
        fail_count    <= failures;
        pending_count <= expected_answers.size();
        checked_count <= compared;
    end

endmodule

// File: bench/fenwick_tree_sum_engine_tb.sv
`timescale 1ns / 1ps
// fenwick_tree_sum_engine_tb: directed and random words through the tree sum engine
// over several size settings and idle patterns. Depends on fts_pkg, the engine RTL
// and fenwick_tree_sum_engine_checker.

module fenwick_tree_sum_engine_tb;

    localparam int         MAX_POSITIONS   = 65536;
    // Nothing is accepted during the clearing pass after reset over all MAX_POSITIONS entries,
    // so the quiet-cycle limit sits above the length of that pass.
    localparam int         WATCHDOG_LIMIT  = 300000;
    localparam int         TAIL_CYCLES     = 80;
    localparam int         HOLD_OFF_CYCLES = 400;
    localparam int         PHASE_WORDS     = 150;
    localparam int         PHASES          = 7;
    localparam logic [1:0] CMD_UNKNOWN     = 2'd3;

    logic                               clk         = 1'b0;
    logic                               rst_n       = 1'b0;
    logic                               cfg_wr_en   = 1'b0;
    logic [fts_pkg::POS_W-1:0]          cfg_wr_data = '0;
    logic                               in_valid    = 1'b0;
    logic                               in_ready;
    logic [1:0]                         cmd         = fts_pkg::CMD_POINT_ADD;
    logic [fts_pkg::POS_W-1:0]          first_index = '0;
    logic [fts_pkg::POS_W-1:0]          last_index  = '0;
    logic signed [fts_pkg::DELTA_W-1:0] delta       = '0;
    logic                               out_valid;
    logic                               out_ready   = 1'b0;
    logic signed [fts_pkg::SUM_W-1:0]   range_sum;
    logic                               status;

    int fail_count;
    int pending_count;
    int checked_count;

    // Idle odds in percent for each side, and the long receiver hold-off requests.
    int send_idle_pct = 12;
    int recv_idle_pct = 68;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int words_sent    = 0;
    int size_writes   = 0;

    // stimulus copy, used to aim indices
    logic [fts_pkg::POS_W-1:0] size_now = fts_pkg::SIZE_RESET;

    always #2 clk = ~clk;

    fenwick_tree_sum_engine #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .first_index (first_index),
        .last_index  (last_index),
        .delta       (delta),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .range_sum   (range_sum),
        .status      (status)
    );

    fenwick_tree_sum_engine_checker #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .first_index   (first_index),
        .last_index    (last_index),
        .delta         (delta),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .range_sum     (range_sum),
        .status        (status),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Receiver: random back-pressure, or a long hold-off when one is requested.
    // The hold-off is counted here so the sender can keep pushing meanwhile.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= 1'b0;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served = holds_served + 1;
            hold_left    = HOLD_OFF_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: quiet cycles on both channels end the run.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("fenwick_tree_sum_engine test failed");
                $finish;
            end
        end
    end

    // Offers one word. Entered and left right after a rising edge; valid stays high on
    // return so back-to-back words follow without a gap.
    task automatic send_word(logic [1:0] op, logic [fts_pkg::POS_W-1:0] lo,
                             logic [fts_pkg::POS_W-1:0] hi, logic [fts_pkg::DELTA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        first_index <= lo;
        last_index  <= hi;
        delta       <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Stop offering and wait until every answer is back, plus the tail margin.
    // pending_count is updated with nonblocking writes, so the task waits on the clock before polling it.
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Only called with the engine idle.
    task automatic write_size(logic [fts_pkg::POS_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
        size_now = value;
        size_writes++;
    endtask

    // Mostly well-formed words inside the live range; about one in five is broken.
    task automatic send_random_word();
        int unsigned                 n;
        int unsigned                 pick;
        logic [1:0]                  op;
        logic [fts_pkg::POS_W-1:0]   lo;
        logic [fts_pkg::POS_W-1:0]   hi;
        logic [fts_pkg::DELTA_W-1:0] d;
        n    = (size_now == 0) ? 1 : (size_now > MAX_POSITIONS) ? MAX_POSITIONS
                                                                : 32'(size_now);
        pick = $urandom_range(99);
        op   = (pick < 30) ? fts_pkg::CMD_POINT_ADD
             : (pick < 60) ? fts_pkg::CMD_RANGE_ADD : fts_pkg::CMD_RANGE_SUM;
        lo   = fts_pkg::POS_W'($urandom_range(n, 1));
        hi   = fts_pkg::POS_W'($urandom_range(n, lo));
        if ($urandom_range(9) == 0)
            lo = 1;
        if ($urandom_range(9) == 0)
            hi = fts_pkg::POS_W'(n);
        pick = $urandom_range(3);
        if (pick == 0)
            d = $urandom_range(200) - 100;
        else if (pick == 1)
            d = ($urandom_range(1) == 0) ? 32'h7fff_ffff : 32'h8000_0000;
        else
            d = $urandom;
        if ($urandom_range(99) < 20)
        begin
            case ($urandom_range(4))
                0: op = CMD_UNKNOWN;
                1: lo = '0;
                2: hi = fts_pkg::POS_W'(n + 1 + $urandom_range(100));
                3: lo = hi + fts_pkg::POS_W'(1);   // first above last, or past the end
                default:
                begin
                    lo = fts_pkg::POS_W'($urandom);
                    hi = fts_pkg::POS_W'($urandom);
                end
            endcase
        end
        send_word(op, lo, hi, d);
    endtask

    initial
    begin
        logic [fts_pkg::POS_W-1:0] phase_size [PHASES];
        phase_size = '{17, 0, 131071, 1, 65536, 0, 1000};
        phase_size[5] = fts_pkg::POS_W'($urandom_range(300, 2));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset size: extreme positions and deltas, every
        // command, the unknown command, out-of-range and reversed indices, and a
        // range add whose cancelling update would fall past the end.
        send_word(fts_pkg::CMD_POINT_ADD, 17'd1,      17'd0,      32'h7fff_ffff);
        send_word(fts_pkg::CMD_POINT_ADD, 17'd65536,  17'd0,      32'h8000_0000);
        send_word(fts_pkg::CMD_POINT_ADD, 17'd0,      17'd5,      32'd7);
        send_word(fts_pkg::CMD_POINT_ADD, 17'd65537,  17'd65537,  32'd7);
        send_word(fts_pkg::CMD_POINT_ADD, 17'h1ffff,  17'h1ffff,  32'hffff_ffff);
        send_word(fts_pkg::CMD_RANGE_ADD, 17'd1,      17'd65536,  32'hffff_ffff);
        send_word(fts_pkg::CMD_RANGE_ADD, 17'd100,    17'd200,    32'd12345);
        send_word(fts_pkg::CMD_RANGE_ADD, 17'd5,      17'd4,      32'd9);
        send_word(fts_pkg::CMD_RANGE_ADD, 17'd32768,  17'd32768,  32'h5555_5555);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd1,      17'd65536,  32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd1,      17'd1,      32'hffff_ffff);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd65536,  17'd65536,  32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd150,    17'd150,    32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd0,      17'd5,      32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd3,      17'd65537,  32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd7,      17'd6,      32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd1,      17'd0,      32'd0);
        send_word(CMD_UNKNOWN,            17'd1,      17'd2,      32'd1);
        send_word(fts_pkg::CMD_POINT_ADD, 17'd2,      17'h1ffff,  32'hffff_ffff);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd1,      17'd2,      32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd32767,  17'd32769,  32'd0);
        send_word(fts_pkg::CMD_RANGE_SUM, 17'd99,     17'd201,    32'd0);

        // Random phases, each at its own size. The store is not cleared between
        // them, so shrinking and regrowing the size walks over stale nodes.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_answers();
            write_size(phase_size[phase]);
            if (phase == 2)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 12;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // long receiver stall with the sender still pushing: the queue fills
                hold_requests <= hold_requests + 1;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                send_random_word();
                // sender pause mid-phase until every answer is back
                if (phase == 5 && i == PHASE_WORDS / 2)
                    drain_answers();
            end
        end
        drain_answers();

        $display("Run covered %0d words over %0d size settings; %0d answers compared.",
                 words_sent, size_writes + 1, checked_count);
        if (fail_count == 0)
            $display("fenwick_tree_sum_engine test passed");
        else
        begin
            $display("%0d mismatches in total", fail_count);
            $display("fenwick_tree_sum_engine test failed");
        end
        $finish;
    end

endmodule

// File: fenwick_tree_sum_engine.f
design/fts_pkg.sv
design/fts_front.sv
design/fts_queue.sv
design/fts_back.sv
design/fenwick_tree_sum_engine.sv
bench/fenwick_tree_sum_engine_checker.sv
bench/fenwick_tree_sum_engine_tb.sv
